### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cond must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/ocs_pkg.sv
// Types and fixed constants for the OCS to WCS arbitrary-axis transform.
// No dependencies.
package ocs_pkg;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] elevation;
    } ocs_in_t;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic               saturated;
    } ocs_out_t;

    // sign-magnitude vector fed to a normalizer lane
    typedef struct packed {
        logic [2:0][63:0] mag;
        logic [2:0]       neg;
    } sm_vec_t;

    // unit vector, Q1.30 components
    typedef logic [2:0][31:0] uvec_t;

    localparam int UNIT_FRAC  = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int FRONT_LAT  = 3;
    localparam int LANE_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int MERGE_LAT  = 4;

endpackage

### rtl/ocs_norm_lane.sv
// One normalizer lane: scales a sign-magnitude vector to unit length, Q1.30.
// Pipelined: max, bit search, shift, squares, sum, isqrt, rounding, dividers, sign. Uses ocs_pkg.
module ocs_norm_lane (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  ocs_pkg::sm_vec_t vec,
    output logic             out_valid,
    output ocs_pkg::uvec_t   unit
);
    import ocs_pkg::*;

    // stage A: largest magnitude
    logic [63:0]      a_max_next, a_max_reg;
    logic [2:0][63:0] a_mag_reg;
    logic [2:0]       a_neg_reg;
    logic             a_v_reg;

    always_comb
    begin
        a_max_next = vec.mag[0];
        if (vec.mag[1] > a_max_next)
        begin
            a_max_next = vec.mag[1];
        end
        if (vec.mag[2] > a_max_next)
        begin
            a_max_next = vec.mag[2];
        end
    end

    // stage B: top bit position
    logic [5:0]       b_pos_next, b_pos_reg;
    logic             b_zero_next, b_zero_reg;
    logic [2:0][63:0] b_mag_reg;
    logic [2:0]       b_neg_reg;
    logic             b_v_reg;

    always_comb
    begin
        b_pos_next = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (a_max_reg[i])
            begin
                b_pos_next = 6'(i);
            end
        end
        b_zero_next = (a_max_reg == '0);
    end

    // stage C: bring the largest magnitude into [2^30, 2^31)
    logic [2:0][30:0] c_c_next, c_c_reg;
    logic [2:0]       c_neg_reg;
    logic             c_zero_reg;
    logic             c_v_reg;

    always_comb
    begin
        logic [63:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            if (b_pos_reg >= 6'd30)
            begin
                sh = b_mag_reg[i] >> (b_pos_reg - 6'd30);
            end
            else
            begin
                sh = b_mag_reg[i] << (6'd30 - b_pos_reg);
            end
            c_c_next[i] = sh[30:0];
        end
    end

    // stage D: squares
    logic [2:0][61:0] d_sq_next, d_sq_reg;
    logic [2:0][30:0] d_c_reg;
    logic [2:0]       d_neg_reg;
    logic             d_zero_reg;
    logic             d_v_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_sq_next[i] = c_c_reg[i] * c_c_reg[i];
        end
    end

    // stage E: sum of squares
    logic [63:0]      e_sum_next, e_sum_reg;
    logic [2:0][30:0] e_c_reg;
    logic [2:0]       e_neg_reg;
    logic             e_zero_reg;
    logic             e_v_reg;

    assign e_sum_next = 64'(d_sq_reg[0]) + 64'(d_sq_reg[1]) + 64'(d_sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_max_reg  <= a_max_next;
        a_mag_reg  <= vec.mag;
        a_neg_reg  <= vec.neg;
        b_pos_reg  <= b_pos_next;
        b_zero_reg <= b_zero_next;
        b_mag_reg  <= a_mag_reg;
        b_neg_reg  <= a_neg_reg;
        c_c_reg    <= c_c_next;
        c_neg_reg  <= b_neg_reg;
        c_zero_reg <= b_zero_reg;
        d_sq_reg   <= d_sq_next;
        d_c_reg    <= c_c_reg;
        d_neg_reg  <= c_neg_reg;
        d_zero_reg <= c_zero_reg;
        e_sum_reg  <= e_sum_next;
        e_c_reg    <= d_c_reg;
        e_neg_reg  <= d_neg_reg;
        e_zero_reg <= d_zero_reg;
    end

    // integer square root, one root bit per stage
    logic [35:0]      sq_rem_reg  [SQRT_STEPS];
    logic [31:0]      sq_root_reg [SQRT_STEPS];
    logic [63:0]      sq_n_reg    [SQRT_STEPS];
    logic [2:0][30:0] sq_c_reg    [SQRT_STEPS];
    logic [2:0]       sq_neg_reg  [SQRT_STEPS];
    logic             sq_zero_reg [SQRT_STEPS];
    logic             sq_v_reg    [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_sqrt
        logic [35:0]      rem_in, rem_sh, rem_next, trial;
        logic [31:0]      root_in, root_next;
        logic [63:0]      n_in;
        logic [2:0][30:0] c_in;
        logic [2:0]       neg_in;
        logic             zero_in, v_in;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = e_sum_reg;
            assign c_in    = e_c_reg;
            assign neg_in  = e_neg_reg;
            assign zero_in = e_zero_reg;
            assign v_in    = e_v_reg;
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[s-1];
            assign root_in = sq_root_reg[s-1];
            assign n_in    = sq_n_reg[s-1];
            assign c_in    = sq_c_reg[s-1];
            assign neg_in  = sq_neg_reg[s-1];
            assign zero_in = sq_zero_reg[s-1];
            assign v_in    = sq_v_reg[s-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[33:0], n_in[63-2*s -: 2]};
            trial  = {2'b00, root_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[s] <= 1'b0;
            end
            else
            begin
                sq_v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_rem_reg[s]  <= rem_next;
            sq_root_reg[s] <= root_next;
            sq_n_reg[s]    <= n_in;
            sq_c_reg[s]    <= c_in;
            sq_neg_reg[s]  <= neg_in;
            sq_zero_reg[s] <= zero_in;
        end
    end

    // dividend with rounding term: c * 2^30 + len / 2
    logic [31:0]      len;
    logic [2:0][61:0] p_num_next, p_num_reg;
    logic [31:0]      p_len_reg;
    logic [2:0]       p_neg_reg;
    logic             p_zero_reg;
    logic             p_v_reg;

    assign len = sq_root_reg[SQRT_STEPS-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_num_next[i] = {1'b0, sq_c_reg[SQRT_STEPS-1][i], 30'b0} + 62'(len >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
        end
        else
        begin
            p_v_reg <= sq_v_reg[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        p_num_reg  <= p_num_next;
        p_len_reg  <= len;
        p_neg_reg  <= sq_neg_reg[SQRT_STEPS-1];
        p_zero_reg <= sq_zero_reg[SQRT_STEPS-1];
    end

    // restoring dividers, one quotient bit per stage, three components side by side
    logic [2:0][61:0] dv_rem_reg  [DIV_STEPS];
    logic [2:0][30:0] dv_q_reg    [DIV_STEPS];
    logic [31:0]      dv_len_reg  [DIV_STEPS];
    logic [2:0]       dv_neg_reg  [DIV_STEPS];
    logic             dv_zero_reg [DIV_STEPS];
    logic             dv_v_reg    [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int B = DIV_STEPS - 1 - k;
        logic [2:0][61:0] rem_in, rem_next;
        logic [2:0][30:0] q_in, q_next;
        logic [31:0]      len_in;
        logic [2:0]       neg_in;
        logic             zero_in, v_in;
        logic [62:0]      dsub;

        if (k == 0)
        begin : g_first
            assign rem_in  = p_num_reg;
            assign q_in    = '0;
            assign len_in  = p_len_reg;
            assign neg_in  = p_neg_reg;
            assign zero_in = p_zero_reg;
            assign v_in    = p_v_reg;
        end
        else
        begin : g_next
            assign rem_in  = dv_rem_reg[k-1];
            assign q_in    = dv_q_reg[k-1];
            assign len_in  = dv_len_reg[k-1];
            assign neg_in  = dv_neg_reg[k-1];
            assign zero_in = dv_zero_reg[k-1];
            assign v_in    = dv_v_reg[k-1];
        end

        assign dsub = 63'(len_in) << B;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = rem_in[i];
                q_next[i]   = q_in[i];
                if ({1'b0, rem_in[i]} >= dsub)
                begin
                    rem_next[i]  = rem_in[i] - dsub[61:0];
                    q_next[i][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k] <= 1'b0;
            end
            else
            begin
                dv_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[k]  <= rem_next;
            dv_q_reg[k]    <= q_next;
            dv_len_reg[k]  <= len_in;
            dv_neg_reg[k]  <= neg_in;
            dv_zero_reg[k] <= zero_in;
        end
    end

    // apply sign; an all-zero vector stays zero
    uvec_t unit_next, unit_reg;
    logic  out_v_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_zero_reg[DIV_STEPS-1])
            begin
                unit_next[i] = '0;
            end
            else if (dv_neg_reg[DIV_STEPS-1][i])
            begin
                unit_next[i] = 32'd0 - {1'b0, dv_q_reg[DIV_STEPS-1][i]};
            end
            else
            begin
                unit_next[i] = {1'b0, dv_q_reg[DIV_STEPS-1][i]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= dv_v_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
    end

    assign out_valid = out_v_reg;
    assign unit      = unit_reg;

endmodule

### rtl/ocs_merge.sv
// Merge stage: world = px*Ax + py*Ay + pz*N, rounded and saturated.
// Takes the three lane unit vectors and the delayed point. Uses ocs_pkg.
module ocs_merge #(
    parameter int COORD_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ocs_pkg::uvec_t    ux,
    input  ocs_pkg::uvec_t    uy,
    input  ocs_pkg::uvec_t    un,
    input  logic [2:0][31:0]  pt,
    output logic              out_valid,
    output ocs_pkg::ocs_out_t res
);
    import ocs_pkg::*;

    localparam logic [63:0] LIM_NEG = 64'd1 << (COORD_WIDTH - 1);
    localparam logic [63:0] LIM_POS = LIM_NEG - 64'd1;
    localparam logic [63:0] HALF    = 64'd1 << (UNIT_FRAC - 1);

    // M1: nine products
    logic signed [63:0] m1_prod_next [3][3];
    logic signed [63:0] m1_prod_reg  [3][3];
    logic               m1_v_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            m1_prod_next[j][0] = $signed(pt[0]) * $signed(ux[j]);
            m1_prod_next[j][1] = $signed(pt[1]) * $signed(uy[j]);
            m1_prod_next[j][2] = $signed(pt[2]) * $signed(un[j]);
        end
    end

    // M2: sums
    logic signed [63:0] m2_acc_next [3];
    logic signed [63:0] m2_acc_reg  [3];
    logic               m2_v_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            m2_acc_next[j] = m1_prod_reg[j][0] + m1_prod_reg[j][1] + m1_prod_reg[j][2];
        end
    end

    // M3: magnitude, round half away from zero
    logic [2:0][63:0] m3_mag_next, m3_mag_reg;
    logic [2:0]       m3_neg_next, m3_neg_reg;
    logic             m3_v_reg;

    always_comb
    begin
        logic [63:0] absv;
        logic [63:0] rnd;
        for (int j = 0; j < 3; j++)
        begin
            m3_neg_next[j] = m2_acc_reg[j][63];
            absv = m3_neg_next[j] ? 64'd0 - 64'(m2_acc_reg[j]) : 64'(m2_acc_reg[j]);
            rnd  = absv + HALF;
            m3_mag_next[j] = rnd >> UNIT_FRAC;
        end
    end

    // M4: saturate
    logic [2:0][31:0] m4_w_next;
    logic             m4_sat_next;
    ocs_out_t         res_reg;
    logic             m4_v_reg;

    always_comb
    begin
        logic [63:0] mag;
        logic [63:0] sv;
        m4_sat_next = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            mag = m3_mag_reg[j];
            if (m3_neg_reg[j])
            begin
                if (mag > LIM_NEG)
                begin
                    mag = LIM_NEG;
                    m4_sat_next = 1'b1;
                end
                sv = 64'd0 - mag;
            end
            else
            begin
                if (mag > LIM_POS)
                begin
                    mag = LIM_POS;
                    m4_sat_next = 1'b1;
                end
                sv = mag;
            end
            m4_w_next[j] = sv[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
            m4_v_reg <= 1'b0;
        end
        else
        begin
            m1_v_reg <= in_valid;
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
            m4_v_reg <= m3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_prod_reg <= m1_prod_next;
        m2_acc_reg  <= m2_acc_next;
        m3_mag_reg  <= m3_mag_next;
        m3_neg_reg  <= m3_neg_next;
        res_reg.world_x   <= m4_w_next[0];
        res_reg.world_y   <= m4_w_next[1];
        res_reg.world_z   <= m4_w_next[2];
        res_reg.saturated <= m4_sat_next;
    end

    assign out_valid = m4_v_reg;
    assign res       = res_reg;

endmodule

### rtl/ocs_to_wcs_arbitrary_axis_unit.sv
// Top level of the OCS to WCS arbitrary-axis point transform.
// Uses ocs_pkg, ocs_norm_lane, ocs_merge and assert_macros.svh.
//
// Takes one beat per clock: busy stays low, so a beat is taken at every edge
// where start is high. Each beat gives exactly one result, shown on result
// for one cycle with done high, after the beat passes the front stages F1 to F3,
// the normalizer lanes and the merge stages M1 to M4. Lane latency is set by
// the 32-stage square root and the 31-stage quotient pipelines. Results
// leave in the order beats arrive; the receiver must take them as they come.
module ocs_to_wcs_arbitrary_axis_unit #(
    parameter int COORD_WIDTH      = 32,
    parameter int COORD_FRAC_BITS  = 16,
    parameter int NORMAL_FRAC_BITS = 30
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ocs_pkg::ocs_in_t  item,
    output logic              done,
    output ocs_pkg::ocs_out_t result
);
    import ocs_pkg::*;

    `include "assert_macros.svh"

    localparam logic [63:0] NEAR = 64'd1 << (NORMAL_FRAC_BITS - 6);
    // |pz| * 1e9 < 2^F  <=>  |pz| < ceil(2^F / 1e9)
    localparam logic [63:0] ZLIM = ((64'd1 << COORD_FRAC_BITS) + 64'd999999999) / 64'd1000000000;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // F1: magnitudes, signs, axis choice, z substitution
    logic [2:0][31:0] f1_mag_next, f1_mag_reg;
    logic [2:0]       f1_sgn_reg;
    logic [2:0]       f1_nz_next, f1_nz_reg;
    logic             f1_near_next, f1_near_reg;
    logic [2:0][31:0] f1_pt_next, f1_pt_reg;
    logic             f1_v_reg;
    logic [31:0]      pz_mag;

    always_comb
    begin
        f1_mag_next[0] = item.normal_x[31] ? 32'd0 - item.normal_x : item.normal_x;
        f1_mag_next[1] = item.normal_y[31] ? 32'd0 - item.normal_y : item.normal_y;
        f1_mag_next[2] = item.normal_z[31] ? 32'd0 - item.normal_z : item.normal_z;
        f1_nz_next[0]  = (item.normal_x != '0);
        f1_nz_next[1]  = (item.normal_y != '0);
        f1_nz_next[2]  = (item.normal_z != '0);
        f1_near_next   = (64'(f1_mag_next[0]) < NEAR) && (64'(f1_mag_next[1]) < NEAR);
        pz_mag         = item.point_z[31] ? 32'd0 - item.point_z : item.point_z;
        f1_pt_next[0]  = item.point_x;
        f1_pt_next[1]  = item.point_y;
        f1_pt_next[2]  = (64'(pz_mag) < ZLIM) ? item.elevation : item.point_z;
    end

    // F2: products of normal magnitudes
    logic [63:0]      f2_xx_next, f2_yy_next, f2_zz_next;
    logic [63:0]      f2_xy_next, f2_xz_next, f2_yz_next;
    logic [63:0]      f2_xx_reg, f2_yy_reg, f2_zz_reg;
    logic [63:0]      f2_xy_reg, f2_xz_reg, f2_yz_reg;
    logic [2:0][31:0] f2_mag_reg;
    logic [2:0]       f2_sgn_reg, f2_nz_reg;
    logic             f2_near_reg;
    logic [2:0][31:0] f2_pt_reg;
    logic             f2_v_reg;

    assign f2_xx_next = f1_mag_reg[0] * f1_mag_reg[0];
    assign f2_yy_next = f1_mag_reg[1] * f1_mag_reg[1];
    assign f2_zz_next = f1_mag_reg[2] * f1_mag_reg[2];
    assign f2_xy_next = f1_mag_reg[0] * f1_mag_reg[1];
    assign f2_xz_next = f1_mag_reg[0] * f1_mag_reg[2];
    assign f2_yz_next = f1_mag_reg[1] * f1_mag_reg[2];

    // F3: build Ax, Ay, N in sign-magnitude form
    sm_vec_t          f3_ax_next, f3_ay_next, f3_n_next;
    sm_vec_t          f3_ax_reg, f3_ay_reg, f3_n_reg;
    logic [2:0][31:0] f3_pt_reg;
    logic             f3_v_reg;
    logic             sx, sy, sz, posx, posy;

    always_comb
    begin
        sx   = f2_sgn_reg[0];
        sy   = f2_sgn_reg[1];
        sz   = f2_sgn_reg[2];
        posx = !sx && f2_nz_reg[0];
        posy = !sy && f2_nz_reg[1];
        if (f2_near_reg)
        begin
            // Wy x N = (nz, 0, -nx); N x Ax = (-nx*ny, nx^2+nz^2, -ny*nz)
            f3_ax_next.mag[0] = 64'(f2_mag_reg[2]);
            f3_ax_next.neg[0] = sz;
            f3_ax_next.mag[1] = '0;
            f3_ax_next.neg[1] = 1'b0;
            f3_ax_next.mag[2] = 64'(f2_mag_reg[0]);
            f3_ax_next.neg[2] = posx;
            f3_ay_next.mag[0] = f2_xy_reg;
            f3_ay_next.neg[0] = (f2_xy_reg != '0) && (sx == sy);
            f3_ay_next.mag[1] = f2_xx_reg + f2_zz_reg;
            f3_ay_next.neg[1] = 1'b0;
            f3_ay_next.mag[2] = f2_yz_reg;
            f3_ay_next.neg[2] = (f2_yz_reg != '0) && (sy == sz);
        end
        else
        begin
            // Wz x N = (-ny, nx, 0); N x Ax = (-nz*nx, -nz*ny, nx^2+ny^2)
            f3_ax_next.mag[0] = 64'(f2_mag_reg[1]);
            f3_ax_next.neg[0] = posy;
            f3_ax_next.mag[1] = 64'(f2_mag_reg[0]);
            f3_ax_next.neg[1] = sx;
            f3_ax_next.mag[2] = '0;
            f3_ax_next.neg[2] = 1'b0;
            f3_ay_next.mag[0] = f2_xz_reg;
            f3_ay_next.neg[0] = (f2_xz_reg != '0) && (sz == sx);
            f3_ay_next.mag[1] = f2_yz_reg;
            f3_ay_next.neg[1] = (f2_yz_reg != '0) && (sz == sy);
            f3_ay_next.mag[2] = f2_xx_reg + f2_yy_reg;
            f3_ay_next.neg[2] = 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            f3_n_next.mag[i] = 64'(f2_mag_reg[i]);
            f3_n_next.neg[i] = f2_sgn_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg <= accept;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_mag_reg  <= f1_mag_next;
        f1_sgn_reg  <= {item.normal_z[31], item.normal_y[31], item.normal_x[31]};
        f1_nz_reg   <= f1_nz_next;
        f1_near_reg <= f1_near_next;
        f1_pt_reg   <= f1_pt_next;
        f2_xx_reg   <= f2_xx_next;
        f2_yy_reg   <= f2_yy_next;
        f2_zz_reg   <= f2_zz_next;
        f2_xy_reg   <= f2_xy_next;
        f2_xz_reg   <= f2_xz_next;
        f2_yz_reg   <= f2_yz_next;
        f2_mag_reg  <= f1_mag_reg;
        f2_sgn_reg  <= f1_sgn_reg;
        f2_nz_reg   <= f1_nz_reg;
        f2_near_reg <= f1_near_reg;
        f2_pt_reg   <= f1_pt_reg;
        f3_ax_reg   <= f3_ax_next;
        f3_ay_reg   <= f3_ay_next;
        f3_n_reg    <= f3_n_next;
        f3_pt_reg   <= f2_pt_reg;
    end

    // three normalizer lanes
    logic  ax_v, ay_v, an_v;
    uvec_t ux, uy, un;

    ocs_norm_lane u_lane_ax (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f3_v_reg),
        .vec       (f3_ax_reg),
        .out_valid (ax_v),
        .unit      (ux)
    );

    ocs_norm_lane u_lane_ay (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f3_v_reg),
        .vec       (f3_ay_reg),
        .out_valid (ay_v),
        .unit      (uy)
    );

    ocs_norm_lane u_lane_n (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f3_v_reg),
        .vec       (f3_n_reg),
        .out_valid (an_v),
        .unit      (un)
    );

    // point rides alongside the lanes
    logic [2:0][31:0] pt_reg [LANE_LAT];

    always_ff @(posedge clk)
    begin
        pt_reg[0] <= f3_pt_reg;
        for (int i = 1; i < LANE_LAT; i++)
        begin
            pt_reg[i] <= pt_reg[i-1];
        end
    end

    ocs_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (an_v),
        .ux        (ux),
        .uy        (uy),
        .un        (un),
        .pt        (pt_reg[LANE_LAT-1]),
        .out_valid (done),
        .res       (result)
    );

    `ASSERT_NEVER(a_lanes_aligned, (ax_v != an_v) || (ay_v != an_v), "normalizer lanes out of step")
    `ASSERT_ALWAYS(a_lane_latency, f3_v_reg |-> ##LANE_LAT an_v, "lane latency mismatch")
    `ASSERT_ALWAYS(a_merge_latency, an_v |-> ##MERGE_LAT done, "merge latency mismatch")

endmodule
